FILE: design/tiled_rgb_histogram_defines.svh
// ----------------------------------------------------------------------------
// Tiled RGB histogram: assertion macros
// Shared assertion forms; the enclosing scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef TILED_RGB_HISTOGRAM_DEFINES_SVH
`define TILED_RGB_HISTOGRAM_DEFINES_SVH

// Same-cycle implication.
`define TRH_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/trh_pkg.sv
// ----------------------------------------------------------------------------
// Tiled RGB histogram package
// Types and fixed constants shared by the front, queue, back and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package trh_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int NUM_CH      = 3;
    localparam int CMD_TILE_W  = 6;
    localparam int CMD_XT_W    = 7;
    localparam int COL_W       = 11;
    localparam int LINE_W      = 12;
    localparam int BAND_W      = 8;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_COUNT_W = 24;
    localparam int BLOG_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH  = 3'd0,
        REG_X_TILES    = 3'd1,
        REG_TILE_WIDTH = 3'd2,
        REG_BAND_LINES = 3'd3,
        REG_BANDS      = 3'd4,
        REG_BINS_LOG2  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic {
        KIND_READ    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [11:0] row_width;
        logic [4:0]  x_tiles;
        logic [11:0] tile_width;
        logic [11:0] band_lines;
        logic [7:0]  bands_per_frame;
        logic [3:0]  bins_log2;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic                  clear;
        logic                  count_en;
        logic                  in_range;
        logic                  scan;
        logic                  done;
        logic [CMD_TILE_W-1:0] tile;
        logic [SAMPLE_W-1:0]   bin_r;
        logic [SAMPLE_W-1:0]   bin_g;
        logic [SAMPLE_W-1:0]   bin_b;
        logic [CMD_XT_W-1:0]   xt;
        logic [BLOG_W-1:0]     blog;
        logic [BAND_W-1:0]     band;
    } cmd_t;

    typedef struct packed {
        kind_t                  kind;
        logic [3:0]             tile_index;
        logic [OUT_COUNT_W-1:0] red_count;
        logic [OUT_COUNT_W-1:0] green_count;
        logic [OUT_COUNT_W-1:0] blue_count;
        logic [SAMPLE_W-1:0]    red_mode;
        logic [SAMPLE_W-1:0]    green_mode;
        logic [SAMPLE_W-1:0]    blue_mode;
        logic [BAND_W-1:0]      band_index;
        logic                   frame_done;
        logic                   last;
    } res_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic {
        F_RUN,
        F_DIV
    } front_state_t;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_PIX_RD,
        B_PIX_WR,
        B_READ_RD,
        B_READ_OUT,
        B_SCAN_RD,
        B_SCAN_DRAIN,
        B_SCAN_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: design/trh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/trh_front.sv
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts items, tracks column, tile, line and band, and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module trh_front import trh_pkg::*; #(
    parameter int MAX_TILES = 16,
    parameter int MAX_BINS  = 256,
    parameter int MAX_ROW   = 2048
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         tw_written,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         operation,
    input  logic [7:0]   red,
    input  logic [7:0]   green,
    input  logic [7:0]   blue,
    input  logic [3:0]   tile_select,
    input  logic [7:0]   bin_select,
    input  logic         q_full,
    input  back_status_t bstat,
    output logic         push,
    output cmd_t         push_cmd
);

    localparam int XT_W        = $clog2(MAX_TILES + 1);
    localparam int BIN_CAP_RAW = $clog2(MAX_BINS + 1) - 1;
    localparam int BIN_CAP     = (BIN_CAP_RAW > 8) ? 8 : BIN_CAP_RAW;

    front_state_t      state_reg, state_next;
    logic              resync_reg, resync_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [11:0]       off_reg, off_next;
    logic [XT_W-1:0]   tile_reg, tile_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              clr_pend_reg, clr_pend_next;
    logic [3:0]        div_cnt_reg, div_cnt_next;
    logic [COL_W-1:0]  div_num_reg, div_num_next;
    logic [11:0]       div_rem_reg, div_rem_next;
    logic [COL_W-1:0]  div_q_reg, div_q_next;

    logic [11:0]       rw, tw, bl;
    logic [7:0]        bpf;
    logic [XT_W-1:0]   xt;
    logic [3:0]        blog, shift;
    logic              accept;
    logic [11:0]       col_inc;
    logic [12:0]       line_inc, off_inc, trial;
    logic [8:0]        band_inc;
    logic              row_end, band_end, done, tile_adv, ge;
    logic [11:0]       rem_step;
    logic [COL_W-1:0]  q_step;

    // Registers at zero act as one; row width, tile count and bins_log2 are clamped to their limits.
    always_comb
    begin
        rw = (cfg.row_width == 12'd0) ? 12'd1 : cfg.row_width;
        if (32'(rw) > MAX_ROW)
        begin
            rw = 12'(MAX_ROW);
        end
        tw  = (cfg.tile_width == 12'd0) ? 12'd1 : cfg.tile_width;
        bl  = (cfg.band_lines == 12'd0) ? 12'd1 : cfg.band_lines;
        bpf = (cfg.bands_per_frame == 8'd0) ? 8'd1 : cfg.bands_per_frame;
        if (cfg.x_tiles == 5'd0)
        begin
            xt = XT_W'(1);
        end
        else if (32'(cfg.x_tiles) > MAX_TILES)
        begin
            xt = XT_W'(MAX_TILES);
        end
        else
        begin
            xt = XT_W'(cfg.x_tiles);
        end
        blog = (cfg.bins_log2 == 4'd0) ? 4'd1 : cfg.bins_log2;
        if (32'(blog) > BIN_CAP)
        begin
            blog = 4'(BIN_CAP);
        end
        shift = 4'd8 - blog;
    end

    assign in_stall = q_full || bstat.init_busy || (state_reg != F_RUN) || resync_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 12'd1;
        row_end  = !(col_inc < rw);
        line_inc = {1'b0, line_reg} + 13'd1;
        band_end = row_end && !(line_inc < {1'b0, bl});
        band_inc = {1'b0, band_reg} + 9'd1;
        done     = !(band_inc < {1'b0, bpf});
        off_inc  = {1'b0, off_reg} + 13'd1;
        tile_adv = !(off_inc < {1'b0, tw});

        // One restoring division step: remainder and quotient of column / tile width.
        trial    = {div_rem_reg, div_num_reg[COL_W-1]};
        ge       = (trial >= {1'b0, tw});
        rem_step = ge ? 12'(trial - {1'b0, tw}) : 12'(trial);
        q_step   = {div_q_reg[COL_W-2:0], ge};
    end

    always_comb
    begin
        state_next    = state_reg;
        resync_next   = resync_reg;
        col_next      = col_reg;
        off_next      = off_reg;
        tile_next     = tile_reg;
        line_next     = line_reg;
        band_next     = band_reg;
        clr_pend_next = clr_pend_reg;
        div_cnt_next  = div_cnt_reg;
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        div_q_next    = div_q_reg;
        push          = 1'b0;
        push_cmd      = '0;

        case (state_reg)
            F_RUN:
            begin
                if (resync_reg)
                begin
                    state_next   = F_DIV;
                    resync_next  = 1'b0;
                    div_cnt_next = 4'd0;
                    div_num_next = col_reg;
                    div_rem_next = 12'd0;
                    div_q_next   = '0;
                end
                else if (accept)
                begin
                    push = 1'b1;
                    if (operation == OP_READ)
                    begin
                        push_cmd.op       = OP_READ;
                        push_cmd.in_range = (32'(tile_select) < MAX_TILES)
                                            && (32'(bin_select) < MAX_BINS);
                        push_cmd.tile     = CMD_TILE_W'(tile_select);
                        push_cmd.bin_r    = bin_select;
                    end
                    else
                    begin
                        push_cmd.op       = OP_PIXEL;
                        push_cmd.clear    = clr_pend_reg;
                        push_cmd.count_en = (tile_reg < xt);
                        push_cmd.tile     = CMD_TILE_W'(tile_reg);
                        push_cmd.bin_r    = red >> shift;
                        push_cmd.bin_g    = green >> shift;
                        push_cmd.bin_b    = blue >> shift;
                        push_cmd.scan     = band_end;
                        push_cmd.done     = done;
                        push_cmd.xt       = CMD_XT_W'(xt);
                        push_cmd.blog     = blog;
                        push_cmd.band     = band_reg;
                        clr_pend_next     = 1'b0;
                        if (row_end)
                        begin
                            col_next  = '0;
                            off_next  = 12'd0;
                            tile_next = '0;
                            if (band_end)
                            begin
                                line_next     = '0;
                                band_next     = done ? '0 : 8'(band_inc);
                                clr_pend_next = 1'b1;
                            end
                            else
                            begin
                                line_next = 12'(line_inc);
                            end
                        end
                        else
                        begin
                            col_next = 11'(col_inc);
                            // The column wraps at its width only when the row is longer.
                            if (col_reg == '1)
                            begin
                                off_next  = 12'd0;
                                tile_next = '0;
                            end
                            else if (tile_adv)
                            begin
                                off_next = 12'd0;
                                if (32'(tile_reg) < MAX_TILES)
                                begin
                                    tile_next = tile_reg + XT_W'(1);
                                end
                            end
                            else
                            begin
                                off_next = 12'(off_inc);
                            end
                        end
                    end
                end
            end
            F_DIV:
            begin
                div_cnt_next = div_cnt_reg + 4'd1;
                div_num_next = {div_num_reg[COL_W-2:0], 1'b0};
                div_rem_next = rem_step;
                div_q_next   = q_step;
                if (32'(div_cnt_reg) == COL_W - 1)
                begin
                    state_next = F_RUN;
                    off_next   = rem_step;
                    tile_next  = (32'(q_step) >= MAX_TILES) ? XT_W'(MAX_TILES)
                                                            : XT_W'(q_step);
                end
            end
            default:
            begin
                state_next = F_RUN;
            end
        endcase

        if (tw_written)
        begin
            resync_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_RUN;
            resync_reg   <= 1'b0;
            col_reg      <= '0;
            off_reg      <= 12'd0;
            tile_reg     <= '0;
            line_reg     <= '0;
            band_reg     <= '0;
            clr_pend_reg <= 1'b0;
            div_cnt_reg  <= 4'd0;
        end
        else
        begin
            state_reg    <= state_next;
            resync_reg   <= resync_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
            tile_reg     <= tile_next;
            line_reg     <= line_next;
            band_reg     <= band_next;
            clr_pend_reg <= clr_pend_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
    end

endmodule

`default_nettype wire

FILE: design/trh_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trh_queue import trh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: design/trh_back.sv
// ----------------------------------------------------------------------------
// Histogram back end
// Owns the count store: clears, counts pixels, serves reads, scans for modes.
// ----------------------------------------------------------------------------
`default_nettype none

module trh_back import trh_pkg::*; #(
    parameter int MAX_TILES  = 16,
    parameter int MAX_BINS   = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  cmd_t         head,
    output logic         pop,
    output back_status_t bstat,
    output logic         out_valid,
    input  logic         out_stall,
    output res_t         out_res
);

    localparam int TILE_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int DEPTH  = MAX_TILES * (2 ** BIN_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XT_W   = $clog2(MAX_TILES + 1);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    addr_cnt_reg, addr_cnt_next;
    logic [XT_W-1:0]      scan_tile_reg, scan_tile_next;
    logic [BIN_W-1:0]     scan_bin_reg, scan_bin_next;
    logic                 pend_vld_reg;
    logic [BIN_W-1:0]     pend_bin_reg;
    logic [COUNT_BITS-1:0] best_reg [NUM_CH];
    logic [COUNT_BITS-1:0] best_next [NUM_CH];
    logic [BIN_W-1:0]     mode_reg [NUM_CH];
    logic [BIN_W-1:0]     mode_next [NUM_CH];
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg, out_res_next;

    logic                  rd_en, wr_en;
    logic [ADDR_W-1:0]     rd_addr [NUM_CH];
    logic [ADDR_W-1:0]     wr_addr [NUM_CH];
    logic [COUNT_BITS-1:0] wr_data [NUM_CH];
    logic [COUNT_BITS-1:0] rd_data [NUM_CH];

    logic                  out_free;
    logic [BIN_W-1:0]      nb_m1;
    logic                  tile_last;
    logic [BIN_W-1:0]      pix_bin [NUM_CH];

    function automatic logic [ADDR_W-1:0] addr_of(input logic [TILE_W-1:0] t,
                                                  input logic [BIN_W-1:0] b);
        return ADDR_W'({t, b});
    endfunction

    // One store per channel so that a pixel updates its three bins at once.
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_store
        trh_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr[c]),
            .wr_data (wr_data[c]),
            .rd_en   (rd_en),
            .rd_addr (rd_addr[c]),
            .rd_data (rd_data[c])
        );
    end

    assign out_free        = !out_valid_reg || !out_stall;
    assign bstat.init_busy = (state_reg == B_INIT);
    assign out_valid       = out_valid_reg;
    assign out_res         = out_res_reg;

    always_comb
    begin
        nb_m1      = BIN_W'((9'd1 << cmd_reg.blog) - 9'd1);
        tile_last  = (CMD_XT_W'(scan_tile_reg) + CMD_XT_W'(1)) == cmd_reg.xt;
        pix_bin[0] = BIN_W'(cmd_reg.bin_r);
        pix_bin[1] = BIN_W'(cmd_reg.bin_g);
        pix_bin[2] = BIN_W'(cmd_reg.bin_b);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_cnt_next  = addr_cnt_reg;
        scan_tile_next = scan_tile_reg;
        scan_bin_next  = scan_bin_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        out_res_next   = out_res_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            rd_addr[c] = '0;
            wr_addr[c] = '0;
            wr_data[c] = '0;
        end

        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                wr_en = 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    wr_addr[c] = addr_cnt_reg;
                end
                addr_cnt_next = addr_cnt_reg + ADDR_W'(1);
                if (addr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    addr_cnt_next = '0;
                    state_next    = (state_reg == B_INIT) ? B_IDLE : B_PIX_RD;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.op == OP_READ)
                    begin
                        state_next = B_READ_RD;
                    end
                    else if (head.clear)
                    begin
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        state_next = B_PIX_RD;
                    end
                end
            end
            B_PIX_RD:
            begin
                rd_en = 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    rd_addr[c] = addr_of(TILE_W'(cmd_reg.tile), pix_bin[c]);
                end
                state_next = B_PIX_WR;
            end
            B_PIX_WR:
            begin
                wr_en = cmd_reg.count_en;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    wr_addr[c] = addr_of(TILE_W'(cmd_reg.tile), pix_bin[c]);
                    wr_data[c] = (rd_data[c] == '1) ? rd_data[c]
                                                    : rd_data[c] + COUNT_BITS'(1);
                end
                if (cmd_reg.scan)
                begin
                    scan_tile_next = '0;
                    scan_bin_next  = '0;
                    state_next     = B_SCAN_RD;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_READ_RD:
            begin
                rd_en = 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    rd_addr[c] = addr_of(TILE_W'(cmd_reg.tile), BIN_W'(cmd_reg.bin_r));
                end
                state_next = B_READ_OUT;
            end
            B_READ_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next            = '0;
                    out_res_next.kind       = KIND_READ;
                    out_res_next.tile_index = 4'(cmd_reg.tile);
                    out_res_next.last       = 1'b1;
                    if (cmd_reg.in_range)
                    begin
                        out_res_next.red_count   = OUT_COUNT_W'(rd_data[0]);
                        out_res_next.green_count = OUT_COUNT_W'(rd_data[1]);
                        out_res_next.blue_count  = OUT_COUNT_W'(rd_data[2]);
                    end
                    state_next = B_IDLE;
                end
            end
            B_SCAN_RD:
            begin
                rd_en = 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    rd_addr[c] = addr_of(TILE_W'(scan_tile_reg), scan_bin_reg);
                end
                if (scan_bin_reg == nb_m1)
                begin
                    state_next = B_SCAN_DRAIN;
                end
                else
                begin
                    scan_bin_next = scan_bin_reg + BIN_W'(1);
                end
            end
            B_SCAN_DRAIN:
            begin
                state_next = B_SCAN_EMIT;
            end
            B_SCAN_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_res_next.kind        = KIND_SUMMARY;
                    out_res_next.tile_index  = 4'(scan_tile_reg);
                    out_res_next.red_count   = OUT_COUNT_W'(best_reg[0]);
                    out_res_next.green_count = OUT_COUNT_W'(best_reg[1]);
                    out_res_next.blue_count  = OUT_COUNT_W'(best_reg[2]);
                    out_res_next.red_mode    = SAMPLE_W'(mode_reg[0]);
                    out_res_next.green_mode  = SAMPLE_W'(mode_reg[1]);
                    out_res_next.blue_mode   = SAMPLE_W'(mode_reg[2]);
                    out_res_next.band_index  = cmd_reg.band;
                    out_res_next.frame_done  = cmd_reg.done;
                    out_res_next.last        = tile_last;
                    if (tile_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        scan_tile_next = scan_tile_reg + XT_W'(1);
                        scan_bin_next  = '0;
                        state_next     = B_SCAN_RD;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Running maximum over the bins of one tile; a bin wins only when strictly
    // larger, so the lowest bin keeps a tie.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            best_next[c] = best_reg[c];
            mode_next[c] = mode_reg[c];
            if (pend_vld_reg && ((pend_bin_reg == '0) || (rd_data[c] > best_reg[c])))
            begin
                best_next[c] = rd_data[c];
                mode_next[c] = pend_bin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            addr_cnt_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_cnt_reg  <= addr_cnt_next;
            pend_vld_reg  <= (state_reg == B_SCAN_RD);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        scan_tile_reg <= scan_tile_next;
        scan_bin_reg  <= scan_bin_next;
        pend_bin_reg  <= scan_bin_reg;
        out_res_reg   <= out_res_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            best_reg[c] <= best_next[c];
            mode_reg[c] <= mode_next[c];
        end
    end

endmodule

`default_nettype wire

FILE: design/tiled_rgb_histogram.sv
// ----------------------------------------------------------------------------
// Tiled RGB histogram
// Per-tile color histograms over horizontal bands with band-end mode summaries.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Carries
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data (register write)
// in        in_valid / in_stall       operation, red, green, blue, tile_select,
//                                     bin_select
// out       out_valid / out_stall     kind, tile_index, counts, modes, band_index,
//                                     frame_done, last
//
// In the back end a pixel or read goes through a queue pop, a store read, and
// a store write or result load, for the read-modify-write of the count store.
// A band-end pixel then runs a mode scan over every bin of each of x_tiles tiles.
// After reset, and before the first pixel of each new band, a clearing pass
// writes MAX_TILES * 2^clog2(MAX_BINS) entries, one per cycle (4096 by default);
// no item is accepted during the reset pass. A tile_width write re-divides the
// column before the next item. A two-entry queue lets the front end accept
// while the back end works, and the output register holds under out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_rgb_histogram import trh_pkg::*; #(
    parameter int MAX_TILES  = 16,
    parameter int MAX_BINS   = 256,
    parameter int COUNT_BITS = 24,
    parameter int MAX_ROW    = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [3:0]  tile_select,
    input  logic [7:0]  bin_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [3:0]  tile_index,
    output logic [23:0] red_count,
    output logic [23:0] green_count,
    output logic [23:0] blue_count,
    output logic [7:0]  red_mode,
    output logic [7:0]  green_mode,
    output logic [7:0]  blue_mode,
    output logic [7:0]  band_index,
    output logic        frame_done,
    output logic        last
);

    cfg_t         cfg_reg, cfg_next;
    logic         cfg_write;
    logic         tw_written;
    logic         push, pop, q_full, q_empty;
    cmd_t         push_cmd, head;
    back_status_t bstat;
    res_t         out_res;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign tw_written = cfg_write && (cfg_index == REG_TILE_WIDTH);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:  cfg_next.row_width       = cfg_data;
                REG_X_TILES:    cfg_next.x_tiles         = cfg_data[4:0];
                REG_TILE_WIDTH: cfg_next.tile_width      = cfg_data;
                REG_BAND_LINES: cfg_next.band_lines      = cfg_data;
                REG_BANDS:      cfg_next.bands_per_frame = cfg_data[7:0];
                REG_BINS_LOG2:  cfg_next.bins_log2       = cfg_data[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width       <= 12'd352;
            cfg_reg.x_tiles         <= 5'd1;
            cfg_reg.tile_width      <= 12'd352;
            cfg_reg.band_lines      <= 12'd288;
            cfg_reg.bands_per_frame <= 8'd1;
            cfg_reg.bins_log2       <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    trh_front #(
        .MAX_TILES (MAX_TILES),
        .MAX_BINS  (MAX_BINS),
        .MAX_ROW   (MAX_ROW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .tw_written  (tw_written),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .tile_select (tile_select),
        .bin_select  (bin_select),
        .q_full      (q_full),
        .bstat       (bstat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    trh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    trh_back #(
        .MAX_TILES  (MAX_TILES),
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .bstat     (bstat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind        = out_res.kind;
    assign tile_index  = out_res.tile_index;
    assign red_count   = out_res.red_count;
    assign green_count = out_res.green_count;
    assign blue_count  = out_res.blue_count;
    assign red_mode    = out_res.red_mode;
    assign green_mode  = out_res.green_mode;
    assign blue_mode   = out_res.blue_mode;
    assign band_index  = out_res.band_index;
    assign frame_done  = out_res.frame_done;
    assign last        = out_res.last;

endmodule

`default_nettype wire

FILE: design/trh_checker.sv
// ----------------------------------------------------------------------------
// Histogram port checker
// Watches the top level's ports and checks result ordering and shape.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tiled_rgb_histogram_defines.svh"

module trh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [3:0]  tile_index,
    input logic [23:0] red_count,
    input logic [23:0] green_count,
    input logic [23:0] blue_count,
    input logic [7:0]  red_mode,
    input logic [7:0]  green_mode,
    input logic [7:0]  blue_mode,
    input logic [7:0]  band_index,
    input logic        frame_done,
    input logic        last
);

    // A stalled item stays offered.
    `TRH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tile_index) && $stable(red_count) && $stable(green_count) && $stable(blue_count) && $stable(last), "stalled result changed")

    // Read data carries no mode or band information and ends its item.
    `TRH_ASSERT_NOW(a_read_shape, out_valid && !kind, last && red_mode == 8'd0 && green_mode == 8'd0 && blue_mode == 8'd0 && band_index == 8'd0 && !frame_done, "malformed read result")

    // Summaries of one band follow in tile order with nothing in between.
    `TRH_ASSERT_NEXT(a_summary_seq, out_valid && !out_stall && kind && !last, !out_valid || (kind && tile_index == ($past(tile_index) + 4'd1)), "summary out of order")

    // Summaries of one band share band and frame status.
    `TRH_ASSERT_NEXT(a_summary_band, out_valid && !out_stall && kind && !last, !out_valid || (band_index == $past(band_index) && frame_done == $past(frame_done)), "summary band changed")

endmodule

bind tiled_rgb_histogram trh_checker u_trh_checker (.*);

`default_nettype wire
